>>> sv/des_round_function_unit_macros.svh
// ----------------------------------------------------------------------------
// DES round function assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DES_ROUND_FUNCTION_UNIT_MACROS_SVH
`define DES_ROUND_FUNCTION_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DES_RF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("DES round function assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DES_RF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("DES round function assertion failed");

`endif

>>> sv/des_rf_pkg.sv
// ----------------------------------------------------------------------------
// DES round function package
// Selection tables for the E expansion, the P permutation and the S-boxes.
// ----------------------------------------------------------------------------
package des_rf_pkg;

    localparam int HALF_W = 32;
    localparam int KEY_W  = 48;
    localparam int NUM_BOX = 8;

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [5:0]        sel_t;
    typedef logic [3:0]        nibble_t;

    // DES bit numbers, bit 1 being the most significant.
    localparam sel_t E_SEL [0:KEY_W-1] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam sel_t P_SEL [0:HALF_W-1] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam nibble_t SBOX [0:NUM_BOX-1][0:63] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

endpackage

>>> sv/des_rf_expand.sv
// ----------------------------------------------------------------------------
// DES round function expansion
// Spreads the right half to 48 bits with the E table and mixes in the subkey.
// ----------------------------------------------------------------------------
module des_rf_expand
    import des_rf_pkg::*;
(
    input  half_t right_half,
    input  key_t  round_key,
    output key_t  mixed
);

    key_t expanded;

    always_comb
    begin
        for (int i = 0; i < KEY_W; i++)
        begin
            expanded[KEY_W-1-i] = right_half[HALF_W - int'(E_SEL[i])];
        end
    end

    assign mixed = expanded ^ round_key;

endmodule

>>> sv/des_rf_subst.sv
// ----------------------------------------------------------------------------
// DES round function substitution
// Runs the eight S-boxes on the mixed word and applies the P permutation.
// ----------------------------------------------------------------------------
module des_rf_subst
    import des_rf_pkg::*;
(
    input  key_t  mixed,
    output half_t f_value
);

    half_t sbox_word;

    always_comb
    begin
        logic [5:0] chunk;
        logic [5:0] idx;
        for (int j = 0; j < NUM_BOX; j++)
        begin
            chunk = mixed[KEY_W-1-6*j -: 6];
            idx   = {chunk[5], chunk[0], chunk[4:1]};
            sbox_word[HALF_W-1-4*j -: 4] = SBOX[j][idx];
        end
    end

    always_comb
    begin
        for (int i = 0; i < HALF_W; i++)
        begin
            f_value[HALF_W-1-i] = sbox_word[HALF_W - int'(P_SEL[i])];
        end
    end

endmodule

>>> sv/des_round_function_unit.sv
// ----------------------------------------------------------------------------
// DES round function unit
// Computes f(R, K) = P(S(E(R) xor K)) for one transaction per clock. A
// transaction is taken whenever start is high; busy never rises. The result
// appears on f_out with done high for one cycle. The operand registers
// capture the transaction, and the expansion, S-box and permutation logic
// then feeds the result register that drives f_out.
// Transactions may be issued on every cycle, and results are never held back,
// so the receiver must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "des_round_function_unit_macros.svh"

module des_round_function_unit
    import des_rf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] right_half,
    input  logic [47:0] round_key,
    output logic        done,
    output logic [31:0] f_out
);

    logic  valid_reg;
    half_t rh_reg;
    key_t  key_reg;
    logic  done_reg;
    half_t f_out_reg;
    key_t  mixed;
    half_t f_out_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            rh_reg  <= right_half;
            key_reg <= round_key;
        end
        if (valid_reg)
        begin
            f_out_reg <= f_out_next;
        end
    end

    des_rf_expand u_expand (
        .right_half (rh_reg),
        .round_key  (key_reg),
        .mixed      (mixed)
    );

    des_rf_subst u_subst (
        .mixed   (mixed),
        .f_value (f_out_next)
    );

    assign done  = done_reg;
    assign f_out = f_out_reg;

    `DES_RF_ASSERT_SAME(a_start_gives_result, start, ##2 done)
    `DES_RF_ASSERT_NEXT(a_no_result_without_operands, !valid_reg, !done)
    `DES_RF_ASSERT_NEXT(a_same_operands_same_result,
        valid_reg && $past(valid_reg) && $stable(rh_reg) && $stable(key_reg),
        $stable(f_out))

endmodule
